// ===== design/polynomial_string_hash_assert.svh =====
// Assertion macros used by the polynomial string hash checker.
`ifndef POLYNOMIAL_STRING_HASH_ASSERT_SVH
`define POLYNOMIAL_STRING_HASH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/phash_pkg.sv =====
// Shared constants for the polynomial string hash.
package phash_pkg;

    localparam int PH_HASH_WIDTH = 64;
    localparam int PH_RESULT_W   = 64;
    localparam int PH_REG_W      = 64;
    localparam int PH_BYTE_W     = 8;
    localparam int PH_ADDR_W     = 4;

    localparam logic [PH_REG_W-1:0] PH_MULT_RESET = 64'd1000000007;
    localparam logic [PH_REG_W-1:0] PH_MOD_RESET  = 64'd1000000000000000007;

    // Register select, taken from the address bit above the 8-byte offset.
    localparam logic PH_SEL_MULT = 1'b0;
    localparam logic PH_SEL_MOD  = 1'b1;

    // Item kind carried on the input tuser.
    localparam logic PH_FUNC_ABSORB = 1'b0;
    localparam logic PH_FUNC_FINISH = 1'b1;

endpackage

// ===== design/phash_modstep.sv =====
// One step of modular arithmetic: (2*acc or acc) + addend, reduced by the modulus.
module phash_modstep #(
    parameter int HASH_WIDTH = phash_pkg::PH_HASH_WIDTH
) (
    input  logic [HASH_WIDTH-1:0] acc,
    input  logic [HASH_WIDTH-1:0] addend,
    input  logic                  dbl,
    input  logic [HASH_WIDTH:0]   modulus_ext,
    output logic [HASH_WIDTH-1:0] result
);

    logic [HASH_WIDTH+1:0] base;
    logic [HASH_WIDTH+1:0] sum;
    logic [HASH_WIDTH+2:0] diff1;
    logic [HASH_WIDTH+2:0] diff2;

    // Both operands are below the modulus, so the sum is below three times
    // the modulus and at most two subtractions of it are needed.
    always_comb
    begin
        base  = dbl ? {1'b0, acc, 1'b0} : {2'b00, acc};
        sum   = base + {2'b00, addend};
        diff1 = {1'b0, sum} - {2'b00, modulus_ext};
        diff2 = {1'b0, sum} - {1'b0, modulus_ext, 1'b0};
        if (!diff2[HASH_WIDTH+2])
        begin
            result = diff2[HASH_WIDTH-1:0];
        end
        else if (!diff1[HASH_WIDTH+2])
        begin
            result = diff1[HASH_WIDTH-1:0];
        end
        else
        begin
            result = sum[HASH_WIDTH-1:0];
        end
    end

endmodule

// ===== design/polynomial_string_hash.sv =====
// Top level of the polynomial rolling string hash with an APB register port.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: func (finish flag); tdata: data_byte
//  m_axis    out        tdata: hash_value
//  apb       in/out     multiplier at 0x0, modulus at 0x8, 64-bit data
//
// A data byte is absorbed bit-serially by one shared modular add unit, one
// multiplier bit per cycle, after the byte is reduced when it is not below
// the modulus and the held hash when it is not (after a modulus change); the
// input is not ready again until the byte is added. A finish beat loads the
// output register; a stalled output only holds off finish beats.
// Reset is asynchronous and active low; it clears the hash and loads the defaults.
module polynomial_string_hash #(
    parameter int HASH_WIDTH = phash_pkg::PH_HASH_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [phash_pkg::PH_BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                              s_tuser,   // [0] func
    // Output stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [phash_pkg::PH_RESULT_W-1:0] m_tdata,   // [63:0] hash_value
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [phash_pkg::PH_ADDR_W-1:0]   paddr,
    input  logic [phash_pkg::PH_REG_W-1:0]    pwdata,
    output logic [phash_pkg::PH_REG_W-1:0]    prdata,
    output logic                              pready
);

    import phash_pkg::*;

    localparam int CNT_W = $clog2(HASH_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BRED,   // reduce the byte modulo the modulus
        S_HRED,   // reduce the held hash modulo the modulus
        S_MUL,    // shift-and-add multiply, most significant multiplier bit first
        S_ADD     // add the reduced byte
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [HASH_WIDTH-1:0]   acc_reg, acc_next;
    logic [HASH_WIDTH-1:0]   hm_reg, hm_next;
    logic [PH_BYTE_W-1:0]    bm_reg, bm_next;
    logic                    hflag_reg, hflag_next;
    logic [HASH_WIDTH-1:0]   hash_reg, hash_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [PH_RESULT_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [PH_REG_W-1:0]     mult_reg;
    logic [PH_REG_W-1:0]     mod_reg;

    logic [HASH_WIDTH-1:0]   mod_w;
    logic [HASH_WIDTH-1:0]   mult_w;
    logic [HASH_WIDTH:0]     modulus_ext;
    logic [HASH_WIDTH-1:0]   step_addend;
    logic                    step_dbl;
    logic [HASH_WIDTH-1:0]   step_result;
    logic                    in_beat;
    logic                    last_step;
    logic                    byte_big;
    logic                    hash_big;

    // A modulus of zero in the low HASH_WIDTH bits stands for 2^HASH_WIDTH;
    // carrying it one bit wider lets the same unit handle the wrapping case.
    assign mod_w       = mod_reg[HASH_WIDTH-1:0];
    assign mult_w      = mult_reg[HASH_WIDTH-1:0];
    assign modulus_ext = {(mod_w == '0), mod_w};

    assign byte_big = ((HASH_WIDTH+1)'(s_tdata) >= modulus_ext);
    assign hash_big = ({1'b0, hash_reg} >= modulus_ext);

    // Finish beats need the output register free; data beats do not.
    assign s_tready = (state_reg == S_IDLE) &&
                      ((s_tuser == PH_FUNC_ABSORB) || !m_tvalid_reg || m_tready);
    assign in_beat  = s_tvalid && s_tready;
    assign last_step = (cnt_reg == '0);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Register port: always ready, decoded on the 8-byte offset bit.
    assign pready = 1'b1;
    assign prdata = (paddr[3] == PH_SEL_MOD) ? mod_reg : mult_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= PH_MULT_RESET;
            mod_reg  <= PH_MOD_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[3] == PH_SEL_MOD)
            begin
                mod_reg <= pwdata;
            end
            else
            begin
                mult_reg <= pwdata;
            end
        end
    end

    // Operand selection for the shared unit.
    always_comb
    begin
        step_dbl    = 1'b1;
        step_addend = '0;
        case (state_reg)
            S_BRED:
            begin
                step_addend = HASH_WIDTH'(bm_reg[cnt_reg[2:0]]);
            end
            S_HRED:
            begin
                step_addend = HASH_WIDTH'(hash_reg[cnt_reg]);
            end
            S_MUL:
            begin
                step_addend = mult_w[cnt_reg] ? hm_reg : '0;
            end
            S_ADD:
            begin
                step_dbl    = 1'b0;
                step_addend = HASH_WIDTH'(bm_reg);
            end
            default:
            begin
                step_addend = '0;
            end
        endcase
    end

    phash_modstep #(
        .HASH_WIDTH (HASH_WIDTH)
    ) u_modstep (
        .acc         (acc_reg),
        .addend      (step_addend),
        .dbl         (step_dbl),
        .modulus_ext (modulus_ext),
        .result      (step_result)
    );

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        hm_next       = hm_reg;
        bm_next       = bm_reg;
        hflag_next    = hflag_reg;
        hash_next     = hash_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    if (s_tuser == PH_FUNC_FINISH)
                    begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = PH_RESULT_W'(hash_reg);
                        hash_next     = '0;
                    end
                    else
                    begin
                        // Unreduced operands are used as they are when
                        // already below the modulus.
                        hm_next    = hash_reg;
                        bm_next    = s_tdata;
                        hflag_next = hash_big;
                        acc_next   = '0;
                        if (byte_big)
                        begin
                            state_next = S_BRED;
                            cnt_next   = CNT_W'(PH_BYTE_W - 1);
                        end
                        else if (hash_big)
                        begin
                            state_next = S_HRED;
                            cnt_next   = CNT_W'(HASH_WIDTH - 1);
                        end
                        else
                        begin
                            state_next = S_MUL;
                            cnt_next   = CNT_W'(HASH_WIDTH - 1);
                        end
                    end
                end
            end
            S_BRED:
            begin
                acc_next = step_result;
                cnt_next = cnt_reg - 1'b1;
                if (last_step)
                begin
                    bm_next    = step_result[PH_BYTE_W-1:0];
                    acc_next   = '0;
                    cnt_next   = CNT_W'(HASH_WIDTH - 1);
                    state_next = hflag_reg ? S_HRED : S_MUL;
                end
            end
            S_HRED:
            begin
                acc_next = step_result;
                cnt_next = cnt_reg - 1'b1;
                if (last_step)
                begin
                    hm_next    = step_result;
                    acc_next   = '0;
                    cnt_next   = CNT_W'(HASH_WIDTH - 1);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next = step_result;
                cnt_next = cnt_reg - 1'b1;
                if (last_step)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                hash_next  = step_result;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            hflag_reg    <= 1'b0;
            hash_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            hflag_reg    <= hflag_next;
            hash_reg     <= hash_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        hm_reg      <= hm_next;
        bm_reg      <= bm_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== design/phash_checker.sv =====
// Port-level checker for the polynomial string hash, bound to the top level.
`include "polynomial_string_hash_assert.svh"

module phash_checker #(
    parameter int HASH_WIDTH = phash_pkg::PH_HASH_WIDTH
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [phash_pkg::PH_RESULT_W-1:0] m_tdata
);

    import phash_pkg::*;

    localparam logic [PH_RESULT_W-1:0] HIGH_MASK =
        ~((PH_RESULT_W'(1) << HASH_WIDTH) - PH_RESULT_W'(1));

    logic absorb_beat;
    logic finish_beat;

    assign absorb_beat = s_tvalid && s_tready && (s_tuser == PH_FUNC_ABSORB);
    assign finish_beat = s_tvalid && s_tready && (s_tuser == PH_FUNC_FINISH);

    // A data byte keeps the unit busy, so the input stops being ready.
    `PH_ASSERT_NEXT(a_busy_after_byte, clk, rst_n, absorb_beat, !s_tready, "ready after data beat")

    // A finish always produces a result in the next cycle.
    `PH_ASSERT_NEXT(a_result_after_finish, clk, rst_n, finish_beat, m_tvalid, "no result after finish")

    // A finish is only taken when the output register can accept it.
    `PH_ASSERT_NOW(a_finish_room, clk, rst_n, finish_beat, !m_tvalid || m_tready, "finish overran output")

    // Results never carry bits above the hash width.
    `PH_ASSERT_NOW(a_hash_width, clk, rst_n, m_tvalid, (m_tdata & HIGH_MASK) == '0, "hash too wide")

    // A stalled result holds.
    `PH_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

endmodule

bind polynomial_string_hash phash_checker #(
    .HASH_WIDTH (HASH_WIDTH)
) u_phash_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the polynomial string hash: streams, registers and hash values.
module testbench;
    import phash_pkg::*;

    localparam int GAP_MAX       = 11;
    localparam int SETTLE_CYCLES = 200;      // covers the longest byte absorb, with both reductions
    localparam int PHASE_ITEMS   = 100;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam logic [PH_REG_W-1:0] ALL_ONES = '1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [PH_BYTE_W-1:0]   s_tdata = '0;
    logic                   s_tuser = PH_FUNC_ABSORB;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [PH_RESULT_W-1:0] m_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PH_ADDR_W-1:0]   paddr = '0;
    logic [PH_REG_W-1:0]    pwdata = '0;
    logic [PH_REG_W-1:0]    prdata;
    logic                   pready;

    // Predictor state: the hash being built and the register contents.
    logic [PH_HASH_WIDTH-1:0] hash_acc = '0;
    logic [PH_REG_W-1:0]      mult_reg = PH_MULT_RESET;
    logic [PH_REG_W-1:0]      mod_reg  = PH_MOD_RESET;
    logic [PH_RESULT_W-1:0]   hashes_due[$];

    int   errors = 0;
    int   cycle_count = 0;
    logic tx_burst = 1'b0;
    logic rx_burst = 1'b0;
    int   rx_wait = 0;

    polynomial_string_hash uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),    // [7:0] data_byte
        .s_tuser (s_tuser),    // [0] func
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),    // [63:0] hash_value
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One absorb step at full precision. A modulus of zero means 2^64, so the
    // sum simply wraps in 64 bits.
    function automatic logic [63:0] poly_step(input logic [63:0] held, input logic [63:0] k,
                                              input logic [63:0] m, input logic [7:0] data_val);
        logic [128:0] full;
        full = {65'd0, held} * {65'd0, k} + {121'd0, data_val};
        if (m == 64'd0)
            return full[63:0];
        return 64'(full % {65'd0, m});
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Extreme bytes turn up often so that every bit is seen at both values.
    function automatic logic [7:0] pick_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Drive one input beat after a random gap and update the predictor once it
    // has been taken. The beat stays valid on return; drain_and_rest lowers it.
    task automatic send_beat(input logic kind, input logic [7:0] data_val);
        int gap;
        if ($urandom_range(0, 19) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data_val;
        do
            @(posedge clk);
        while (!s_tready);
        if (kind == PH_FUNC_FINISH)
        begin
            hashes_due.push_back(hash_acc);
            hash_acc = '0;
        end
        else
        begin
            hash_acc = poly_step(hash_acc, mult_reg, mod_reg, data_val);
        end
    endtask

    task automatic absorb_bytes(input int count);
        repeat (count) send_beat(PH_FUNC_ABSORB, pick_byte());
    endtask

    // Wait for every hash to come back, then long enough for a byte still
    // being absorbed to complete.
    task automatic drain_and_rest();
        s_tvalid <= 1'b0;
        while (hashes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write a register, then read it back over the same port.
    task automatic write_reg(input logic sel, input logic [PH_REG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (sel == PH_SEL_MULT)
            mult_reg = value;
        else
            mod_reg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== value)
        begin
            $error("prdata: expected %016h, got %016h", value, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [PH_REG_W-1:0] k, input logic [PH_REG_W-1:0] m);
        write_reg(PH_SEL_MULT, k);
        write_reg(PH_SEL_MOD, m);
    endtask

    // Empty strings and a short string under the reset values.
    task automatic test_empty_and_defaults();
        send_beat(PH_FUNC_FINISH, 8'hFF);
        send_beat(PH_FUNC_FINISH, 8'h00);
        send_beat(PH_FUNC_ABSORB, 8'h00);
        send_beat(PH_FUNC_ABSORB, 8'hFF);
        send_beat(PH_FUNC_ABSORB, 8'h80);
        send_beat(PH_FUNC_ABSORB, 8'h01);
        send_beat(PH_FUNC_FINISH, 8'h5A);
        drain_and_rest();
    endtask

    // Largest multiplier and modulus, then a multiplier of one and a modulus of two.
    task automatic test_register_extremes();
        set_regs(ALL_ONES, ALL_ONES);
        repeat (3) send_beat(PH_FUNC_ABSORB, 8'hFF);
        send_beat(PH_FUNC_FINISH, 8'h00);
        drain_and_rest();
        set_regs(64'd1, 64'd2);
        send_beat(PH_FUNC_ABSORB, 8'hFF);
        send_beat(PH_FUNC_ABSORB, 8'h01);
        send_beat(PH_FUNC_FINISH, 8'hFF);
        drain_and_rest();
    endtask

    // A zero modulus wraps, a modulus of one always gives zero, and a zero
    // multiplier leaves only the byte reduced by the modulus.
    task automatic test_special_moduli();
        set_regs(ALL_ONES, 64'd0);
        repeat (2) send_beat(PH_FUNC_ABSORB, 8'hFF);
        send_beat(PH_FUNC_FINISH, 8'h00);
        drain_and_rest();
        write_reg(PH_SEL_MOD, 64'd1);
        send_beat(PH_FUNC_ABSORB, 8'h7E);
        send_beat(PH_FUNC_FINISH, 8'h00);
        drain_and_rest();
        set_regs(64'd0, 64'd7);
        send_beat(PH_FUNC_ABSORB, 8'hFF);
        send_beat(PH_FUNC_FINISH, 8'h00);
        drain_and_rest();
    endtask

    // The modulus shrinks in the middle of a string. A finish must return the
    // held value untouched; a further byte must reduce it fully.
    task automatic test_modulus_change();
        set_regs(ALL_ONES, ALL_ONES);
        send_beat(PH_FUNC_ABSORB, 8'hFF);
        send_beat(PH_FUNC_ABSORB, 8'hC3);
        drain_and_rest();
        write_reg(PH_SEL_MOD, 64'd5);
        send_beat(PH_FUNC_FINISH, 8'h00);
        drain_and_rest();
        write_reg(PH_SEL_MOD, ALL_ONES);
        send_beat(PH_FUNC_ABSORB, 8'hFF);
        send_beat(PH_FUNC_ABSORB, 8'h3C);
        drain_and_rest();
        write_reg(PH_SEL_MOD, 64'd9);
        send_beat(PH_FUNC_ABSORB, 8'h02);
        send_beat(PH_FUNC_FINISH, 8'h00);
        drain_and_rest();
    endtask

    // Random strings under a series of register settings. A phase may end in
    // the middle of a string, so the next setting applies to a held hash.
    task automatic test_random_strings();
        int   phase;
        int   sent;
        int   len;
        logic leave_open;
        for (phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: set_regs(PH_MULT_RESET, PH_MOD_RESET);
                1: set_regs(rand64(), rand64());
                2: set_regs(ALL_ONES, ALL_ONES);
                3: set_regs(rand64(), 64'd2);
                4: set_regs(rand64(), 64'd0);
                5: set_regs(rand64(), 64'($urandom_range(2, 300)));
                default: set_regs(rand64(), rand64() >> $urandom_range(0, 60));
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12);
                absorb_bytes(len);
                send_beat(PH_FUNC_FINISH, 8'($urandom_range(0, 255)));
                sent += len + 1;
            end
            leave_open = (phase != 6) && ($urandom_range(0, 2) == 0);
            if (leave_open)
                absorb_bytes($urandom_range(1, 5));
            drain_and_rest();
        end
    endtask

    // Output side: random stalls per result, and a check against the oldest
    // expected hash at every accepted beat.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (hashes_due.size() == 0)
            begin
                $error("hash_value: unexpected result %016h", m_tdata);
                errors++;
            end
            else if (m_tdata !== hashes_due[0])
            begin
                $error("hash_value: expected %016h, got %016h", hashes_due[0], m_tdata);
                errors++;
                void'(hashes_due.pop_front());
            end
            else
            begin
                void'(hashes_due.pop_front());
            end
            if ($urandom_range(0, 19) == 0)
                rx_burst = !rx_burst;
            rx_wait = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (rx_wait != 0)
                m_tready <= 1'b0;
        end
        else if (!m_tready)
        begin
            if (rx_wait == 0)
                m_tready <= 1'b1;
            else
                rx_wait--;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_defaults();
        test_register_extremes();
        test_special_moduli();
        test_modulus_change();
        test_random_strings();
        drain_and_rest();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
